// File: rtl/fbgw_pkg.sv
// Shared types, constants and helper functions for the framebuffer glyph writer.
package fbgw_pkg;

  // Character cell geometry
  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_WIDTH  = 8;

  // Scan line index and pixel index widths
  localparam int LINE_W = $clog2(4095 * GLYPH_HEIGHT + 16);
  localparam int PIX_W  = $clog2(4095 * GLYPH_WIDTH + GLYPH_WIDTH);
  localparam int OFF_W  = PIX_W + 3;
  localparam int PROD_W = (LINE_W + 16 > 32) ? LINE_W + 16 : 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

  // Request opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_GLYPH = 1'b1;

  // Supported colour depths
  localparam logic [5:0] DEPTH_8  = 6'd8;
  localparam logic [5:0] DEPTH_16 = 6'd16;
  localparam logic [5:0] DEPTH_24 = 6'd24;
  localparam logic [5:0] DEPTH_32 = 6'd32;
  localparam logic [5:0] PIXEL_BITS_RESET = DEPTH_32;

  // Drawing request
  typedef struct packed {
    logic        op;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [3:0]  glyph_line;
    logic [7:0]  glyph_bits;
    logic [31:0] color;
  } cmd_t;

  // Framebuffer write
  typedef struct packed {
    logic [31:0] write_addr;
    logic [31:0] write_data;
    logic [2:0]  write_bytes;
    logic        last;
  } mem_t;

  // Bytes per pixel, zero for an unsupported depth
  function automatic logic [2:0] depth_bytes(input logic [5:0] bits);
    logic [2:0] nb;
    case (bits)
      DEPTH_8:  nb = 3'd1;
      DEPTH_16: nb = 3'd2;
      DEPTH_24: nb = 3'd3;
      DEPTH_32: nb = 3'd4;
      default:  nb = 3'd0;
    endcase
    return nb;
  endfunction

  // Colour mask for a byte count
  function automatic logic [31:0] depth_mask(input logic [2:0] nb);
    logic [31:0] m;
    case (nb)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/framebuffer_pixel_glyph_writer.sv
// Framebuffer pixel and glyph-row writer: drawing requests in, byte writes out.
//
// Each request passes an input register, a multiply stage (scan line times
// pitch), and an emitter that puts out one framebuffer write per cycle while
// the write channel is not stalled. A pixel request gives at most one write; a
// glyph-row request gives one write per set bit of glyph_bits, lowest bit
// (leftmost pixel) first, with last set on the final one. Requests that give
// no writes (unsupported depth, pixel off screen, empty glyph row) are dropped
// in the pipeline and never reach the emitter. The emitter sets the rate: it
// holds an item until its last write goes out, while the input register and
// the multiply stage can take the next requests. The output register lets the
// next item advance while a write waits on mem_stall.
// Configuration is taken on any cycle with cfg_en, but must only change while
// the block is idle.
module framebuffer_pixel_glyph_writer import fbgw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  // write channel
  output logic                 mem_valid,
  input  logic                 mem_stall,
  output mem_t                 mem,
  // configuration
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // Configuration registers
  logic [31:0] frame_base;
  logic [15:0] line_pitch;
  logic [5:0]  pixel_bits;
  logic [11:0] screen_width;
  logic [11:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base    <= '0;
      line_pitch    <= '0;
      pixel_bits    <= PIXEL_BITS_RESET;
      screen_width  <= '0;
      screen_height <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_FRAME_BASE:    frame_base    <= cfg_data;
        REG_LINE_PITCH:    line_pitch    <= cfg_data[15:0];
        REG_PIXEL_BITS:    pixel_bits    <= cfg_data[5:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid, s2_valid, s3_valid;
  logic s1_move, s2_move, s2_free, s3_free;
  logic out_free, emit, lastbit, accept;

  // Stage 1: input register
  cmd_t s1;

  // Stage 2: product and per-item fields
  logic [31:0]      s2_prod;
  logic [7:0]       s2_mask;
  logic [PIX_W-1:0] s2_x;
  logic [2:0]       s2_nb;
  logic [31:0]      s2_data;

  // Stage 3: emitter
  logic [31:0]      s3_row;
  logic [7:0]       s3_mask;
  logic [PIX_W-1:0] s3_x;
  logic [2:0]       s3_nb;
  logic [31:0]      s3_data;

  // Stage 1 decode
  logic [2:0]        nb1;
  logic              in_bounds;
  logic [7:0]        mask1;
  logic [LINE_W-1:0] line1;
  logic [PROD_W-1:0] prod1;
  logic [PIX_W-1:0]  x1;

  always_comb begin
    nb1       = depth_bytes(pixel_bits);
    in_bounds = (s1.pos_x < screen_width) && (s1.pos_y < screen_height);
    if (nb1 == 3'd0) begin
      mask1 = '0;
    end else if (s1.op == OP_GLYPH) begin
      mask1 = s1.glyph_bits;
    end else begin
      mask1 = {7'b0, in_bounds};
    end
    if (s1.op == OP_GLYPH) begin
      line1 = LINE_W'(s1.pos_y) * LINE_W'(GLYPH_HEIGHT) + LINE_W'(s1.glyph_line);
      x1    = PIX_W'(s1.pos_x) * PIX_W'(GLYPH_WIDTH);
    end else begin
      line1 = LINE_W'(s1.pos_y);
      x1    = PIX_W'(s1.pos_x);
    end
    prod1 = PROD_W'(line1) * PROD_W'(line_pitch);
  end

  // Emitter: lowest set bit picks the next pixel
  logic [2:0]       idx;
  logic [7:0]       mask_clr;
  logic [OFF_W-1:0] offset;
  logic [31:0]      addr;

  always_comb begin
    idx = '0;
    for (int i = GLYPH_WIDTH - 1; i >= 0; i--) begin
      if (s3_mask[i]) idx = 3'(i);
    end
    mask_clr = s3_mask & (s3_mask - 8'd1);
    lastbit  = (mask_clr == 8'd0);
    offset   = OFF_W'(s3_x + PIX_W'(idx)) * OFF_W'(s3_nb);
    addr     = s3_row + 32'(offset);
  end

  // Handshake chain
  assign out_free  = !mem_valid || !mem_stall;
  assign emit      = s3_valid && out_free;
  assign s3_free   = !s3_valid || (emit && lastbit);
  assign s2_move   = s2_valid && s3_free;
  assign s2_free   = !s2_valid || s2_move;
  assign s1_move   = s1_valid && s2_free;
  assign cmd_stall = s1_valid && !s1_move;
  assign accept    = cmd_valid && !cmd_stall;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      mem_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      // items with no writes are dropped here
      if (s1_move) begin
        s2_valid <= (mask1 != 8'd0);
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        s3_valid <= 1'b1;
      end else if (emit && lastbit) begin
        s3_valid <= 1'b0;
      end
      if (emit) begin
        mem_valid <= 1'b1;
      end else if (!mem_stall) begin
        mem_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= cmd;
    end
    if (s1_move) begin
      s2_prod <= prod1[31:0];
      s2_mask <= mask1;
      s2_x    <= x1;
      s2_nb   <= nb1;
      s2_data <= s1.color & depth_mask(nb1);
    end
    if (s2_move) begin
      s3_row  <= frame_base + s2_prod;
      s3_mask <= s2_mask;
      s3_x    <= s2_x;
      s3_nb   <= s2_nb;
      s3_data <= s2_data;
    end else if (emit) begin
      s3_mask <= mask_clr;
    end
    if (emit) begin
      mem.write_addr  <= addr;
      mem.write_data  <= s3_data;
      mem.write_bytes <= s3_nb;
      mem.last        <= lastbit;
    end
  end

endmodule

// File: rtl/fbgw_checker.sv
// Port-level checker for the framebuffer glyph writer, bound to the top level.
module fbgw_checker import fbgw_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_stall,
  input cmd_t                 cmd,
  input logic                 mem_valid,
  input logic                 mem_stall,
  input mem_t                 mem
);

  // A stalled request holds
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("request changed while stalled");

  // A stalled write holds
  a_mem_hold: assert property (@(posedge clk) disable iff (rst)
    mem_valid && mem_stall |=> mem_valid && $stable(mem))
    else $error("write changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !mem_valid && !cmd_stall)
    else $error("pipeline not empty after reset");

  // Byte count is a supported depth
  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    mem_valid |-> (mem.write_bytes == 3'd1 || mem.write_bytes == 3'd2 ||
                   mem.write_bytes == 3'd3 || mem.write_bytes == 3'd4))
    else $error("bad write byte count");

  // Data is masked to the byte count
  a_data_masked: assert property (@(posedge clk) disable iff (rst)
    mem_valid |-> (mem.write_data & ~depth_mask(mem.write_bytes)) == 32'd0)
    else $error("write data not masked to depth");

endmodule

bind framebuffer_pixel_glyph_writer fbgw_checker u_fbgw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .mem_valid (mem_valid),
  .mem_stall (mem_stall),
  .mem       (mem)
);

// File: verif/fbgw_write_checker.sv
// Checker for the framebuffer glyph writer: predicts the writes and compares them.
module fbgw_write_checker import fbgw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  cmd_t                 cmd,
  input  logic                 mem_valid,
  input  logic                 mem_stall,
  input  mem_t                 mem,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   failures,
  output int                   outstanding,
  output int                   writes_checked
);

  // Shadow copy of the configuration registers
  logic [31:0] frame_base_q;
  logic [15:0] line_pitch_q;
  logic [5:0]  pixel_bits_q;
  logic [11:0] screen_w_q;
  logic [11:0] screen_h_q;

  // Writes still owed by the block, oldest first
  mem_t expected_writes[$];

  int fail_count    = 0;
  int checked_count = 0;
  int owed_count    = 0;

  assign failures       = fail_count;
  assign writes_checked = checked_count;
  assign outstanding    = owed_count;

  // Queue up the writes one drawing request should produce
  task automatic predict_writes(input cmd_t req);
    logic [2:0]  nb;
    logic [31:0] colour;
    logic [31:0] row_base;
    logic [15:0] scan_line;
    logic [14:0] column;
    mem_t        w;
    int          total;
    int          seen;
    case (pixel_bits_q)
      DEPTH_8:  nb = 3'd1;
      DEPTH_16: nb = 3'd2;
      DEPTH_24: nb = 3'd3;
      DEPTH_32: nb = 3'd4;
      default:  nb = 3'd0;
    endcase
    // unsupported depth: nothing at all
    if (nb == 3'd0)
      return;
    colour = (nb == 3'd4) ? req.color : req.color & ~(32'hffff_ffff << (8 * nb));
    w.write_data  = colour;
    w.write_bytes = nb;

    if (req.op == OP_PIXEL) begin
      // off-screen pixels are dropped
      if (req.pos_x >= screen_w_q || req.pos_y >= screen_h_q)
        return;
      w.write_addr = frame_base_q + req.pos_y * line_pitch_q + req.pos_x * nb;
      w.last       = 1'b1;
      expected_writes.push_back(w);
      return;
    end

    // glyph row: one write per set bit, bit 0 leftmost, no bounds check
    total     = $countones(req.glyph_bits);
    seen      = 0;
    scan_line = {req.pos_y, req.glyph_line};
    row_base  = frame_base_q + scan_line * line_pitch_q;
    for (int i = 0; i < GLYPH_WIDTH; i++) begin
      if (req.glyph_bits[i]) begin
        seen++;
        column       = {req.pos_x, i[2:0]};
        w.write_addr = row_base + column * nb;
        w.last       = (seen == total);
        expected_writes.push_back(w);
      end
    end
  endtask

  // Report one field that disagrees; returns 1 on a mismatch
  function automatic bit field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Track configuration, predict on accepted requests, check accepted writes
  always @(posedge clk) begin
    mem_t want;
    bit   bad;
    if (rst) begin
      frame_base_q <= '0;
      line_pitch_q <= '0;
      pixel_bits_q <= PIXEL_BITS_RESET;
      screen_w_q   <= '0;
      screen_h_q   <= '0;
      expected_writes.delete();
    end else begin
      if (mem_valid && !mem_stall) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write, expected none actual addr %h data %h bytes %0d last %b",
                   $time, mem.write_addr, mem.write_data, mem.write_bytes, mem.last);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          bad  = 1'b0;
          bad |= field_differs("write_addr", want.write_addr, mem.write_addr);
          bad |= field_differs("write_data", want.write_data, mem.write_data);
          bad |= field_differs("write_bytes", 32'(want.write_bytes), 32'(mem.write_bytes));
          bad |= field_differs("last", 32'(want.last), 32'(mem.last));
          if (bad)
            fail_count++;
          checked_count++;
        end
      end
      if (cmd_valid && !cmd_stall)
        predict_writes(cmd);
      if (cfg_en) begin
        case (cfg_index)
          REG_FRAME_BASE:    frame_base_q <= cfg_data;
          REG_LINE_PITCH:    line_pitch_q <= cfg_data[15:0];
          REG_PIXEL_BITS:    pixel_bits_q <= cfg_data[5:0];
          REG_SCREEN_WIDTH:  screen_w_q   <= cfg_data[11:0];
          REG_SCREEN_HEIGHT: screen_h_q   <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
    owed_count <= expected_writes.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for the framebuffer glyph writer: stimulus, stalls and verdict.
module tb;
  import fbgw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REG_COUNT      = 5;
  localparam int IDX_TOP        = (1 << CFG_IDX_W) - 1;
  localparam int ITEMS_PER_SET  = 28;
  localparam logic [5:0] DEPTH_NONE = 6'd0;
  localparam logic [5:0] DEPTH_ALL_ONES = 6'd63;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_t                 cmd       = '0;
  logic                 mem_valid;
  logic                 mem_stall = 1'b0;
  mem_t                 mem;
  logic                 cfg_en    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int failures;
  int outstanding;
  int writes_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;
  int pixel_reqs    = 0;
  int glyph_reqs    = 0;
  int settings      = 0;
  logic [11:0] cur_width  = '0;
  logic [11:0] cur_height = '0;

  framebuffer_pixel_glyph_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .mem_valid (mem_valid),
    .mem_stall (mem_stall),
    .mem       (mem),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbgw_write_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .mem_valid      (mem_valid),
    .mem_stall      (mem_stall),
    .mem            (mem),
    .cfg_en         (cfg_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .failures       (failures),
    .outstanding    (outstanding),
    .writes_checked (writes_checked)
  );

  always #6 clk = ~clk;

  // Random back-pressure on the write channel
  always @(posedge clk) begin
    mem_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (mem_valid && !mem_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("framebuffer_pixel_glyph_writer verification failed");
    $finish;
  end

  function automatic cmd_t make_req(input logic op, input logic [11:0] x,
                                     input logic [11:0] y, input logic [3:0] line,
                                     input logic [7:0] bits, input logic [31:0] colour);
    cmd_t r;
    r.op         = op;
    r.pos_x      = x;
    r.pos_y      = y;
    r.glyph_line = line;
    r.glyph_bits = bits;
    r.color      = colour;
    return r;
  endfunction

  // Present one request, with random idle cycles ahead of it
  task automatic send_request(input cmd_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      cmd       <= cmd_t'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= req;
    do @(posedge clk); while (cmd_stall);
    if (req.op == OP_PIXEL)
      pixel_reqs++;
    else
      glyph_reqs++;
  endtask

  // Let every owed write come out, then give dropped items time to clear
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; junk above the register width must be ignored
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                           input int width);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (width >= 32) ? value : (($urandom << width) | value);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] base, input logic [15:0] pitch,
                              input logic [5:0] depth, input logic [11:0] width,
                              input logic [11:0] height);
    write_reg(REG_FRAME_BASE, base, 32);
    write_reg(REG_LINE_PITCH, 32'(pitch), 16);
    write_reg(REG_PIXEL_BITS, 32'(depth), 6);
    write_reg(REG_SCREEN_WIDTH, 32'(width), 12);
    write_reg(REG_SCREEN_HEIGHT, 32'(height), 12);
    if ($urandom_range(2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP)), $urandom, 32);
    cfg_en     <= 1'b0;
    cur_width  = width;
    cur_height = height;
    settings++;
  endtask

  task automatic random_config();
    logic [31:0] base;
    logic [15:0] pitch;
    logic [5:0]  depth;
    logic [11:0] dims[2];
    case ($urandom_range(3))
      0: base = '0;
      1: base = 32'hffff_ffff - $urandom_range(255);
      default: base = $urandom;
    endcase
    case ($urandom_range(3))
      0: pitch = '0;
      1: pitch = 16'hffff;
      default: pitch = 16'($urandom);
    endcase
    case ($urandom_range(8))
      0, 1: depth = DEPTH_8;
      2, 3: depth = DEPTH_16;
      4, 5: depth = DEPTH_24;
      6, 7: depth = DEPTH_32;
      default: depth = 6'($urandom);
    endcase
    foreach (dims[i]) begin
      case ($urandom_range(7))
        0: dims[i] = '0;
        1: dims[i] = 12'hfff;
        2, 3: dims[i] = 12'($urandom_range(1, 16));
        default: dims[i] = 12'($urandom_range(1, 4095));
      endcase
    end
    program_regs(base, pitch, depth, dims[0], dims[1]);
  endtask

  function automatic cmd_t random_request();
    cmd_t r;
    r = cmd_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(1) == 0) begin
      r.op = OP_PIXEL;
      // mostly on screen, the rest anywhere
      if (cur_width != 0 && cur_height != 0 && $urandom_range(9) < 8) begin
        r.pos_x = 12'($urandom_range(cur_width - 1));
        r.pos_y = 12'($urandom_range(cur_height - 1));
      end
    end else begin
      r.op = OP_GLYPH;
      case ($urandom_range(9))
        0: r.glyph_bits = 8'h00;
        1, 2: r.glyph_bits = 8'hff;
        default: ;
      endcase
    end
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values: zero screen drops pixels, zero pitch folds glyph rows
    send_request(make_req(OP_PIXEL, 12'd0, 12'd0, 4'd0, 8'h00, 32'h1234_5678));
    send_request(make_req(OP_GLYPH, 12'd5, 12'd3, 4'd7, 8'hff, 32'hcafe_f00d));
    drain();

    // Extremes: wrapping base, widest pitch, full screen, screen edges
    program_regs(32'hffff_fff0, 16'hffff, DEPTH_32, 12'hfff, 12'hfff);
    send_request(make_req(OP_PIXEL, 12'd0, 12'd0, 4'hf, 8'hff, 32'hffff_ffff));
    send_request(make_req(OP_PIXEL, 12'hffe, 12'hffe, 4'd0, 8'h00, 32'h8000_0001));
    send_request(make_req(OP_PIXEL, 12'hfff, 12'd0, 4'd0, 8'h00, 32'h5555_5555));
    send_request(make_req(OP_PIXEL, 12'd0, 12'hfff, 4'd0, 8'h00, 32'haaaa_aaaa));
    send_request(make_req(OP_GLYPH, 12'd9, 12'd9, 4'd3, 8'h00, 32'h0000_0000));
    send_request(make_req(OP_GLYPH, 12'hfff, 12'hfff, 4'hf, 8'hff, 32'hffff_ffff));
    send_request(make_req(OP_GLYPH, 12'd0, 12'd0, 4'd0, 8'h01, 32'h0f0f_0f0f));
    send_request(make_req(OP_GLYPH, 12'd1, 12'd1, 4'd0, 8'h80, 32'hf0f0_f0f0));
    drain();

    // Eight-bit depth written with junk high bits, one-pixel screen
    program_regs(32'h1000_0000, 16'd1, DEPTH_8, 12'd1, 12'd1);
    send_request(make_req(OP_PIXEL, 12'd0, 12'd0, 4'd0, 8'h00, 32'ha5a5_a5a5));
    send_request(make_req(OP_PIXEL, 12'd1, 12'd0, 4'd0, 8'h00, 32'ha5a5_a5a5));
    send_request(make_req(OP_GLYPH, 12'd2, 12'd2, 4'd2, 8'ha5, 32'h1234_5678));
    drain();

    program_regs(32'h0000_0100, 16'd640, DEPTH_16, 12'd320, 12'd200);
    send_request(make_req(OP_PIXEL, 12'd319, 12'd199, 4'd0, 8'h00, 32'hdead_beef));
    send_request(make_req(OP_GLYPH, 12'd39, 12'd12, 4'd9, 8'h5a, 32'hdead_beef));
    drain();

    program_regs(32'h0000_0200, 16'd960, DEPTH_24, 12'd320, 12'd200);
    send_request(make_req(OP_PIXEL, 12'd17, 12'd33, 4'd0, 8'h00, 32'hdead_beef));
    send_request(make_req(OP_GLYPH, 12'd3, 12'd4, 4'd11, 8'hc3, 32'hdead_beef));
    drain();

    // Unsupported depths give nothing
    for (int i = 0; i < 2; i++) begin
      program_regs(32'h0000_0300, 16'd64, i == 0 ? DEPTH_NONE : DEPTH_ALL_ONES,
                   12'hfff, 12'hfff);
      send_request(make_req(OP_PIXEL, 12'd1, 12'd1, 4'd0, 8'h00, 32'h0123_4567));
      send_request(make_req(OP_GLYPH, 12'd1, 12'd1, 4'd1, 8'hff, 32'h0123_4567));
      drain();
    end

    // Random part: three idling profiles, several settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 35; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int set = 0; set < 3; set++) begin
        random_config();
        repeat (ITEMS_PER_SET) send_request(random_request());
        drain();
      end
    end

    $display("Covered %0d pixel and %0d glyph-row requests over %0d register settings,",
             pixel_reqs, glyph_reqs, settings);
    $display("%0d framebuffer writes checked under random and absent stalls on both sides.",
             writes_checked);
    if (failures == 0)
      $display("framebuffer_pixel_glyph_writer verification clean");
    else
      $display("framebuffer_pixel_glyph_writer verification failed");
    $finish;
  end

endmodule
